### rtl/core/midi_overdub_looper_macros.svh
// Assertion macros for the overdub looper.
`ifndef MIDI_OVERDUB_LOOPER_MACROS_SVH
`define MIDI_OVERDUB_LOOPER_MACROS_SVH

`ifndef SYNTH
`define MOL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MOL_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MOL_ASSERT(lbl, clk, rst_n, prop, msg)
`define MOL_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

### rtl/core/mol_pkg.sv
// Types, codes and constants shared by the overdub looper files.
package mol_pkg;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_LIVE  = 3'd1,
		OP_REC   = 3'd2,
		OP_PLAY  = 3'd3,
		OP_STOP  = 3'd4,
		OP_CLEAR = 3'd5,
		OP_TRANS = 3'd6,
		OP_QUANT = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		K_EVENT  = 2'd0,
		K_CLICK  = 2'd1,
		K_ALLOFF = 2'd2,
		K_STATUS = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		TR_STOP = 2'd0,
		TR_PLAY = 2'd1,
		TR_REC  = 2'd2
	} tr_t;

	localparam logic [1:0] CFG_TEMPO = 2'd0;
	localparam logic [1:0] CFG_LOOP  = 2'd1;
	localparam logic [1:0] CFG_METRO = 2'd2;

	localparam logic [8:0]  BPM_MIN    = 9'd30;
	localparam logic [8:0]  BPM_MAX    = 9'd300;
	localparam logic [8:0]  BPM_RESET  = 9'd120;
	localparam logic [31:0] MS_PER_MIN = 32'd60000;
	localparam logic [31:0] QSTEP_NUM  = 32'd3932160000; // minute in ms, 16.16
	localparam logic [31:0] HALF_Q16   = 32'd32768;
	localparam logic [3:0]  NIB_NOTE_OFF = 4'h8;
	localparam logic [3:0]  NIB_NOTE_ON  = 4'h9;
	localparam logic signed [9:0] KEY_MAX = 10'sd127;

	localparam int DIV_W  = 64;
	localparam int DIV_CW = 7;

	typedef struct packed {
		logic [31:0] t_ms;
		logic [7:0]  stat;
		logic [7:0]  d1;
		logic [7:0]  d2;
	} ev_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  stat;
		logic [7:0]  d1;
		logic [7:0]  d2;
		logic        accent;
		tr_t         transport;
		logic [10:0] count;
		logic [31:0] len;
		logic        last;
	} res_t;

	function automatic res_t mk_res(kind_t k, logic [7:0] s, logic [7:0] a,
	                                logic [7:0] b, logic acc);
		res_t r;
		r = '0;
		r.kind = k;
		r.stat = s;
		r.d1 = a;
		r.d2 = b;
		r.accent = acc;
		return r;
	endfunction

endpackage

### rtl/core/mol_if.sv
// Request channels of the overdub looper: command, result and register write.
interface mol_cmd_if;
	logic              valid;
	logic              ready;
	logic [2:0]        op;
	logic [31:0]       now_ms;
	logic [7:0]        status_byte;
	logic [7:0]        data1;
	logic [7:0]        data2;
	logic signed [7:0] semitones;
	logic [7:0]        steps_per_beat;

	modport source (output valid, op, now_ms, status_byte, data1, data2, semitones,
		steps_per_beat, input ready);
	modport sink (input valid, op, now_ms, status_byte, data1, data2, semitones,
		steps_per_beat, output ready);
endinterface

interface mol_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  out_status;
	logic [7:0]  out_data1;
	logic [7:0]  out_data2;
	logic        accent;
	logic [1:0]  transport;
	logic [10:0] event_count;
	logic [31:0] take_length_ms;
	logic        last;

	modport source (output valid, kind, out_status, out_data1, out_data2, accent,
		transport, event_count, take_length_ms, last, input ready);
	modport sink (input valid, kind, out_status, out_data1, out_data2, accent,
		transport, event_count, take_length_ms, last, output ready);
endinterface

interface mol_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [8:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/midi_overdub_looper.sv
// Overdub looper: event store, transport sequencer and shared divider.
// One command request at a time. The event store is a single memory with one
// read and one write port and a registered read, and every walk over it goes
// through that read port. A tick replays at most EVENTS_PER_TICK stored events
// and, with the metronome on, makes two passes of the bit-serial divider.
// Transpose reads and rewrites each stored event. Quantize does one division
// per stored event and then a sort. Sorting is an insertion sort over the
// memory. No clearing pass follows reset.
`include "midi_overdub_looper_macros.svh"

module midi_overdub_looper #(
	parameter int MAX_EVENTS      = 1024,
	parameter int EVENTS_PER_TICK = 61
) (
	input  logic clk,
	input  logic arst_n,
	mol_cfg_if.sink   cfg,
	mol_cmd_if.sink   cmd,
	mol_res_if.source result
);
	import mol_pkg::*;

	localparam int AW = $clog2(MAX_EVENTS);
	localparam int CW = $clog2(MAX_EVENTS + 1);
	localparam int SW = $clog2(EVENTS_PER_TICK + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_TICK_RD, S_TICK_CMP, S_MET, S_MDIV1, S_MDIV2, S_CLICK, S_END,
		S_ANO, S_STATUS, S_LEN, S_LEN_WT, S_TR_RD, S_TR_WR, S_QSTEP, S_Q_RD,
		S_Q_DIV0, S_Q_DIV, S_SORT, S_S_RD, S_S_KEY, S_S_CMP_RD, S_S_CMP
	} state_t;

	ev_t mem [MAX_EVENTS];
	ev_t rd_q;
	ev_t key_q;
	ev_t ent_q;

	state_t state_q, ano_next_q;
	tr_t    trans_q;
	logic [CW-1:0] cnt_q, pidx_q, plim_q, i_q, j_q;
	logic [SW-1:0] sent_q;
	logic [31:0]   origin_q, len_q, lbeat_q, now_q, step_q;
	logic [10:0]   mult_q;
	logic [8:0]    tempo_q;
	logic          loop_q, metro_q;
	logic signed [7:0] semi_q;
	res_t          res_q;
	logic          ov_q;

	logic [DIV_W-1:0]  div_num_q;
	logic [31:0]       div_den_q, div_rem_q;
	logic [DIV_CW-1:0] div_cnt_q;
	logic [32:0]       div_sh;
	logic [32:0]       div_sub;
	logic              div_done;

	logic          mem_re, mem_we;
	logic [AW-1:0] mem_ra, mem_wa;
	ev_t           mem_wd;

	logic [8:0]    bpm;
	logic [31:0]   elapsed;
	logic          can_emit, tick_more, i_more, live_ok, res_ld;
	logic [CW-1:0] cnt_m1, j_m1;
	logic [16:0]   qden;
	logic signed [9:0] key_sum;
	logic [7:0]    key_new;
	logic [42:0]   qprod;
	ev_t           tr_ev;

	assign bpm = (tempo_q < BPM_MIN) ? BPM_MIN : ((tempo_q > BPM_MAX) ? BPM_MAX : tempo_q);
	assign elapsed   = now_q - origin_q;
	assign can_emit  = !ov_q || result.ready;
	assign tick_more = (sent_q < SW'(EVENTS_PER_TICK)) && (pidx_q < plim_q);
	assign i_more    = i_q < cnt_q;
	assign live_ok   = (trans_q == TR_REC) && (cnt_q < CW'(MAX_EVENTS));
	assign cnt_m1    = cnt_q - CW'(1);
	assign j_m1      = j_q - CW'(1);
	assign qden      = 17'(bpm) * 17'(cmd.steps_per_beat);
	assign qprod     = 43'(div_num_q[31:0]) * 43'(mult_q);

	// a result is loaded into the output register this cycle
	assign res_ld = can_emit && ((state_q == S_TICK_CMP && rd_q.t_ms <= elapsed) ||
		state_q == S_CLICK || state_q == S_ANO || state_q == S_STATUS);

	// restoring divider, one quotient bit a cycle
	assign div_sh   = {div_rem_q, div_num_q[DIV_W-1]};
	assign div_sub  = div_sh - {1'b0, div_den_q};
	assign div_done = (div_cnt_q == '0);

	// clamp transposed key to the MIDI range
	always_comb begin
		key_sum = $signed({2'b00, rd_q.d1}) + 10'(semi_q);
		if (key_sum < 10'sd0) begin
			key_new = 8'd0;
		end else if (key_sum > KEY_MAX) begin
			key_new = 8'(KEY_MAX);
		end else begin
			key_new = key_sum[7:0];
		end
		tr_ev = rd_q;
		if (rd_q.stat[7:4] == NIB_NOTE_OFF || rd_q.stat[7:4] == NIB_NOTE_ON) begin
			tr_ev.d1 = key_new;
		end
	end

	always_comb begin
		mem_re = 1'b0;
		mem_ra = '0;
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid && op_t'(cmd.op) == OP_LIVE && live_ok) begin
					mem_we = 1'b1;
					mem_wa = cnt_q[AW-1:0];
					mem_wd = '{t_ms: cmd.now_ms - origin_q, stat: cmd.status_byte,
						d1: cmd.data1, d2: cmd.data2};
				end
			end
			S_TICK_RD: begin
				mem_re = tick_more;
				mem_ra = pidx_q[AW-1:0];
			end
			S_TR_RD, S_Q_RD, S_S_RD: begin
				mem_re = i_more;
				mem_ra = i_q[AW-1:0];
			end
			S_TR_WR: begin
				mem_we = 1'b1;
				mem_wa = i_q[AW-1:0];
				mem_wd = tr_ev;
			end
			S_Q_DIV: begin
				mem_we = div_done;
				mem_wa = i_q[AW-1:0];
				mem_wd = '{t_ms: qprod[31:0], stat: ent_q.stat, d1: ent_q.d1, d2: ent_q.d2};
			end
			S_S_CMP_RD: begin
				if (j_q != '0) begin
					mem_re = 1'b1;
					mem_ra = j_m1[AW-1:0];
				end else begin
					mem_we = 1'b1;
					mem_wa = j_q[AW-1:0];
					mem_wd = key_q;
				end
			end
			S_S_CMP: begin
				mem_we = 1'b1;
				mem_wa = j_q[AW-1:0];
				mem_wd = (rd_q.t_ms > key_q.t_ms) ? rd_q : key_q;
			end
			S_LEN: begin
				mem_re = (cnt_q != '0);
				mem_ra = cnt_m1[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ano_next_q <= S_STATUS;
			trans_q    <= TR_STOP;
			cnt_q      <= '0;
			pidx_q     <= '0;
			plim_q     <= '0;
			i_q        <= '0;
			j_q        <= '0;
			sent_q     <= '0;
			origin_q   <= '0;
			len_q      <= '0;
			lbeat_q    <= '1;
			tempo_q    <= BPM_RESET;
			loop_q     <= 1'b0;
			metro_q    <= 1'b0;
			ov_q       <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_TEMPO: tempo_q <= cfg.data;
					CFG_LOOP:  loop_q <= cfg.data[0];
					CFG_METRO: metro_q <= cfg.data[0];
					default: begin
					end
				endcase
			end

			ov_q <= res_ld || (ov_q && !result.ready);

			if (!div_done) begin
				div_cnt_q <= div_cnt_q - DIV_CW'(1);
				div_num_q <= {div_num_q[DIV_W-2:0], !div_sub[32]};
				div_rem_q <= div_sub[32] ? div_sh[31:0] : div_sub[31:0];
			end

			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						now_q <= cmd.now_ms;
						unique case (op_t'(cmd.op))
							OP_TICK: begin
								sent_q <= '0;
								state_q <= (trans_q == TR_STOP) ? S_STATUS : S_TICK_RD;
							end
							OP_LIVE: begin
								if (live_ok) begin
									cnt_q <= cnt_q + CW'(1);
								end
								state_q <= S_STATUS;
							end
							OP_REC, OP_PLAY: begin
								if (trans_q == TR_STOP &&
								    (op_t'(cmd.op) == OP_REC || cnt_q != '0)) begin
									plim_q   <= cnt_q;
									origin_q <= cmd.now_ms;
									pidx_q   <= '0;
									lbeat_q  <= '1;
									trans_q  <= (op_t'(cmd.op) == OP_REC) ? TR_REC : TR_PLAY;
									state_q  <= S_LEN;
								end else begin
									state_q <= S_STATUS;
								end
							end
							OP_STOP: begin
								trans_q    <= TR_STOP;
								ano_next_q <= (trans_q == TR_REC) ? S_SORT : S_LEN;
								state_q    <= S_ANO;
							end
							OP_CLEAR: begin
								trans_q    <= TR_STOP;
								cnt_q      <= '0;
								len_q      <= '0;
								ano_next_q <= S_STATUS;
								state_q    <= S_ANO;
							end
							OP_TRANS: begin
								semi_q  <= cmd.semitones;
								i_q     <= '0;
								state_q <= S_TR_RD;
							end
							OP_QUANT: begin
								if (cmd.steps_per_beat == 8'd0) begin
									state_q <= S_STATUS;
								end else begin
									div_num_q <= DIV_W'(QSTEP_NUM);
									div_den_q <= 32'(qden);
									div_rem_q <= '0;
									div_cnt_q <= DIV_CW'(DIV_W);
									state_q   <= S_QSTEP;
								end
							end
							default: state_q <= S_STATUS;
						endcase
					end
				end
				S_TICK_RD: begin
					state_q <= tick_more ? S_TICK_CMP : S_MET;
				end
				S_TICK_CMP: begin
					if (rd_q.t_ms <= elapsed) begin
						if (can_emit) begin
							res_q   <= mk_res(K_EVENT, rd_q.stat, rd_q.d1, rd_q.d2, 1'b0);
							pidx_q  <= pidx_q + CW'(1);
							sent_q  <= sent_q + SW'(1);
							state_q <= S_TICK_RD;
						end
					end else begin
						state_q <= S_MET;
					end
				end
				S_MET: begin
					if (metro_q) begin
						div_num_q <= DIV_W'(MS_PER_MIN);
						div_den_q <= 32'(bpm);
						div_rem_q <= '0;
						div_cnt_q <= DIV_CW'(DIV_W);
						state_q   <= S_MDIV1;
					end else begin
						state_q <= S_END;
					end
				end
				S_MDIV1: begin
					if (div_done) begin
						div_num_q <= DIV_W'(elapsed);
						div_den_q <= div_num_q[31:0];
						div_rem_q <= '0;
						div_cnt_q <= DIV_CW'(DIV_W);
						state_q   <= S_MDIV2;
					end
				end
				S_MDIV2: begin
					if (div_done) begin
						if (div_num_q[31:0] != lbeat_q) begin
							lbeat_q <= div_num_q[31:0];
							state_q <= S_CLICK;
						end else begin
							state_q <= S_END;
						end
					end
				end
				S_CLICK: begin
					if (can_emit) begin
						res_q   <= mk_res(K_CLICK, 8'd0, 8'd0, 8'd0, lbeat_q[1:0] == 2'd0);
						state_q <= S_END;
					end
				end
				S_END: begin
					if (trans_q == TR_PLAY && pidx_q >= plim_q) begin
						if (loop_q && len_q != '0) begin
							origin_q   <= now_q;
							pidx_q     <= '0;
							lbeat_q    <= '1;
							ano_next_q <= S_STATUS;
						end else begin
							trans_q    <= TR_STOP;
							ano_next_q <= S_LEN;
						end
						state_q <= S_ANO;
					end else begin
						state_q <= S_STATUS;
					end
				end
				S_ANO: begin
					if (can_emit) begin
						res_q   <= mk_res(K_ALLOFF, 8'd0, 8'd0, 8'd0, 1'b0);
						state_q <= ano_next_q;
					end
				end
				S_STATUS: begin
					if (can_emit) begin
						res_q   <= '{kind: K_STATUS, stat: 8'd0, d1: 8'd0, d2: 8'd0,
							accent: 1'b0, transport: trans_q, count: 11'(cnt_q),
							len: len_q, last: 1'b1};
						state_q <= S_IDLE;
					end
				end
				S_LEN: begin
					if (cnt_q == '0) begin
						len_q   <= '0;
						state_q <= S_STATUS;
					end else begin
						state_q <= S_LEN_WT;
					end
				end
				S_LEN_WT: begin
					len_q   <= rd_q.t_ms + 32'd1;
					state_q <= S_STATUS;
				end
				S_TR_RD: begin
					state_q <= i_more ? S_TR_WR : S_STATUS;
				end
				S_TR_WR: begin
					i_q     <= i_q + CW'(1);
					state_q <= S_TR_RD;
				end
				S_QSTEP: begin
					if (div_done) begin
						step_q  <= div_num_q[31:0];
						mult_q  <= 11'((div_num_q[31:0] + HALF_Q16) >> 16);
						i_q     <= '0;
						state_q <= S_Q_RD;
					end
				end
				S_Q_RD: begin
					state_q <= i_more ? S_Q_DIV0 : S_SORT;
				end
				S_Q_DIV0: begin
					ent_q     <= rd_q;
					div_num_q <= {16'd0, rd_q.t_ms, 16'd0} + DIV_W'(step_q >> 1);
					div_den_q <= step_q;
					div_rem_q <= '0;
					div_cnt_q <= DIV_CW'(DIV_W);
					state_q   <= S_Q_DIV;
				end
				S_Q_DIV: begin
					if (div_done) begin
						i_q     <= i_q + CW'(1);
						state_q <= S_Q_RD;
					end
				end
				S_SORT: begin
					i_q     <= CW'(1);
					state_q <= S_S_RD;
				end
				S_S_RD: begin
					state_q <= i_more ? S_S_KEY : S_LEN;
				end
				S_S_KEY: begin
					key_q   <= rd_q;
					j_q     <= i_q;
					state_q <= S_S_CMP_RD;
				end
				S_S_CMP_RD: begin
					if (j_q != '0) begin
						state_q <= S_S_CMP;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_S_RD;
					end
				end
				S_S_CMP: begin
					// shift the older entry up, or drop the key into its slot
					if (rd_q.t_ms > key_q.t_ms) begin
						j_q     <= j_m1;
						state_q <= S_S_CMP_RD;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign result.valid          = ov_q;
	assign result.kind           = res_q.kind;
	assign result.out_status     = res_q.stat;
	assign result.out_data1      = res_q.d1;
	assign result.out_data2      = res_q.d2;
	assign result.accent         = res_q.accent;
	assign result.transport      = res_q.transport;
	assign result.event_count    = res_q.count;
	assign result.take_length_ms = res_q.len;
	assign result.last           = res_q.last;

	`MOL_ASSERT(a_pidx_in_limit, clk, arst_n, (trans_q != TR_STOP) |-> (pidx_q <= plim_q), "play index past limit")
	`MOL_ASSERT(a_plim_in_store, clk, arst_n, (trans_q == TR_PLAY) |-> (plim_q <= cnt_q), "play limit past store fill")
	`MOL_ASSERT_NEVER(a_div_zero, clk, arst_n, !div_done && div_den_q == '0, "division by zero")
	`MOL_ASSERT(a_status_ends, clk, arst_n, (state_q == S_STATUS && can_emit) |=> (state_q == S_IDLE && ov_q && res_q.last), "status result not last")

endmodule
